[design/boxd_pkg.sv]
// ============================================================================
// Box downscaler package
// Shared widths, register indexes, line store entry and control structs.
// ============================================================================
`default_nettype none

package boxd_pkg;

  // Fixed field widths.
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned SUM_C_W   = 56;
  localparam int unsigned SUM_A_W   = 40;
  localparam int unsigned CNT_W     = 25;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  // Register indexes on the configuration port (byte address 4*index).
  typedef enum logic [1:0] {
    REG_REGION_WIDTH  = 2'd0,
    REG_REGION_HEIGHT = 2'd1,
    REG_TARGET_WIDTH  = 2'd2,
    REG_TARGET_HEIGHT = 2'd3
  } cfg_idx_e;

  // One line store entry: the running sums of one box column.
  typedef struct packed {
    logic [SUM_C_W-1:0] sum_r;
    logic [SUM_C_W-1:0] sum_g;
    logic [SUM_C_W-1:0] sum_b;
    logic [SUM_A_W-1:0] sum_a;
    logic [CNT_W-1:0]   cnt;
  } line_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic edge_start;
    logic restart;
    logic accept;
    logic mul;
    logic acc;
    logic div_start;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic edge_busy;
    logic div_busy;
    logic closing;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[design/boxd_if.sv]
// ============================================================================
// Box downscaler channels
// Pixel input channel and result output channel with valid/ready handshake.
// ============================================================================
`default_nettype none

interface boxd_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] in_red;
  logic [15:0] in_green;
  logic [15:0] in_blue;
  logic [15:0] in_alpha;

  modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface boxd_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;
  logic [15:0] out_alpha;
  logic        row_done;
  logic        frame_done;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, row_done,
                  frame_done, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, row_done,
                  frame_done, output ready);
endinterface

`default_nettype wire

[design/boxd_ram.sv]
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module boxd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/boxd_div.sv]
// ============================================================================
// Iterative divider
// Restoring division, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module boxd_div #(
  parameter int unsigned W   = 16,
  parameter int unsigned Q_W = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [W-1:0]   num_i,
  input  wire logic [W-1:0]   den_i,
  output logic                busy_o,
  output logic      [Q_W-1:0] quot_o,
  output logic      [W-1:0]   rem_o
);

  localparam int unsigned D_W = W + Q_W - 1;
  localparam int unsigned C_W = $clog2(Q_W + 1);

  logic [W-1:0]   n_q;
  logic [D_W-1:0] d_q;
  logic [Q_W-1:0] q_q;
  logic [C_W-1:0] cnt_q;
  logic [D_W:0]   diff;
  logic           fits;

  assign diff = {1'b0, D_W'(n_q)} - {1'b0, d_q};
  assign fits = ~diff[D_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= C_W'(Q_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i;
      d_q <= D_W'(den_i) << (Q_W - 1);
      q_q <= '0;
    end else if (cnt_q != '0) begin
      if (fits) begin
        n_q <= diff[W-1:0];
      end
      q_q <= {q_q[Q_W-2:0], fits};
      d_q <= d_q >> 1;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = q_q;
  assign rem_o  = n_q;

endmodule

`default_nettype wire

[design/boxd_datapath.sv]
// ============================================================================
// Box downscaler datapath
// Traversal counters, box edges, line store, accumulation, dividers, output.
// ============================================================================
`default_nettype none

module boxd_datapath #(
  parameter int unsigned MAX_REGION_DIM   = 4096,
  parameter int unsigned MAX_TARGET_WIDTH = 4096,
  parameter int unsigned SAMPLE_BITS      = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire boxd_pkg::ctrl_cmd_t           cmd_i,
  output boxd_pkg::dp_sts_t                  sts_o,
  input  wire logic [boxd_pkg::CFG_W-1:0]    region_width_i,
  input  wire logic [boxd_pkg::CFG_W-1:0]    region_height_i,
  input  wire logic [boxd_pkg::CFG_W-1:0]    target_width_i,
  input  wire logic [boxd_pkg::CFG_W-1:0]    target_height_i,
  input  wire logic [boxd_pkg::FIELD_W-1:0]  in_red_i,
  input  wire logic [boxd_pkg::FIELD_W-1:0]  in_green_i,
  input  wire logic [boxd_pkg::FIELD_W-1:0]  in_blue_i,
  input  wire logic [boxd_pkg::FIELD_W-1:0]  in_alpha_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic      [boxd_pkg::FIELD_W-1:0]  out_red_o,
  output logic      [boxd_pkg::FIELD_W-1:0]  out_green_o,
  output logic      [boxd_pkg::FIELD_W-1:0]  out_blue_o,
  output logic      [boxd_pkg::FIELD_W-1:0]  out_alpha_o,
  output logic                               row_done_o,
  output logic                               frame_done_o
);

  localparam int unsigned DIM_W  = $clog2(MAX_REGION_DIM + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_REGION_DIM);
  localparam int unsigned TW_W   = $clog2(MAX_TARGET_WIDTH + 1);
  localparam int unsigned TIDX_W = $clog2(MAX_TARGET_WIDTH);
  localparam int unsigned LEN_A  = (DIM_W > boxd_pkg::CFG_W) ? DIM_W : boxd_pkg::CFG_W;
  localparam int unsigned LEN_W  = (TW_W > LEN_A) ? TW_W : LEN_A;
  localparam int unsigned P_W    = 2 * SAMPLE_BITS;
  localparam int unsigned Q_W    = SAMPLE_BITS + 1;
  localparam int unsigned CNUM_W = boxd_pkg::SUM_C_W + 2;
  localparam int unsigned ANUM_W = boxd_pkg::SUM_A_W + 2;
  localparam int unsigned ENT_W  = $bits(boxd_pkg::line_entry_t);

  localparam logic [LEN_W-1:0] MAX_DIM_L = LEN_W'(MAX_REGION_DIM);
  localparam logic [LEN_W-1:0] MAX_TW_L  = LEN_W'(MAX_TARGET_WIDTH);
  localparam logic [LEN_W-1:0] ONE_L     = LEN_W'(1);
  localparam logic [Q_W-1:0]   SAMPLE_MAX = Q_W'((1 << SAMPLE_BITS) - 1);

  // Effective sizes after clamping.
  logic [LEN_W-1:0] cfg_rw, cfg_rh, cfg_tw, cfg_th;
  logic [LEN_W-1:0] rw, rh, tw, th, tw_lim;

  always_comb begin
    cfg_rw = LEN_W'(region_width_i);
    cfg_rh = LEN_W'(region_height_i);
    cfg_tw = LEN_W'(target_width_i);
    cfg_th = LEN_W'(target_height_i);
    rw = (cfg_rw == '0) ? ONE_L : ((cfg_rw > MAX_DIM_L) ? MAX_DIM_L : cfg_rw);
    rh = (cfg_rh == '0) ? ONE_L : ((cfg_rh > MAX_DIM_L) ? MAX_DIM_L : cfg_rh);
    tw_lim = (rw < MAX_TW_L) ? rw : MAX_TW_L;
    tw = (cfg_tw == '0) ? ONE_L : ((cfg_tw > tw_lim) ? tw_lim : cfg_tw);
    th = (cfg_th == '0) ? ONE_L : ((cfg_th > rh) ? rh : cfg_th);
  end

  // Box step per axis: region = step * boxes + leftover.
  logic [LEN_W-1:0] col_step, row_step, col_left, row_left;
  logic             col_busy, row_busy;

  boxd_div #(.W(LEN_W), .Q_W(LEN_W)) u_div_col (
    .clk_i, .rst_ni, .start_i(cmd_i.edge_start), .num_i(rw), .den_i(tw),
    .busy_o(col_busy), .quot_o(col_step), .rem_o(col_left)
  );

  boxd_div #(.W(LEN_W), .Q_W(LEN_W)) u_div_row (
    .clk_i, .rst_ni, .start_i(cmd_i.edge_start), .num_i(rh), .den_i(th),
    .busy_o(row_busy), .quot_o(row_step), .rem_o(row_left)
  );

  // Traversal state.
  logic [IDX_W-1:0]  sc_q, sr_q, tr_q;
  logic [TIDX_W-1:0] tc_q;
  logic [LEN_W-1:0]  col_start_q, row_start_q, next_col_q, next_row_q;
  logic [LEN_W-1:0]  col_rem_q, row_rem_q;

  logic [LEN_W-1:0]  sc_p1, sr_p1, tc_p1, tr_p1;
  logic [LEN_W:0]    col_sum, row_sum;
  logic              col_carry, row_carry;
  logic [LEN_W-1:0]  next_col_adv, next_row_adv, col_rem_adv, row_rem_adv;
  logic              first, closing, row_end, frame_end;

  always_comb begin
    sc_p1 = LEN_W'(sc_q) + ONE_L;
    sr_p1 = LEN_W'(sr_q) + ONE_L;
    tc_p1 = LEN_W'(tc_q) + ONE_L;
    tr_p1 = LEN_W'(tr_q) + ONE_L;
    // Incremental floor(i*len/n): add the step and carry the leftover.
    col_sum      = {1'b0, col_rem_q} + {1'b0, col_left};
    row_sum      = {1'b0, row_rem_q} + {1'b0, row_left};
    col_carry    = (col_sum >= {1'b0, tw});
    row_carry    = (row_sum >= {1'b0, th});
    next_col_adv = next_col_q + col_step + LEN_W'(col_carry);
    next_row_adv = next_row_q + row_step + LEN_W'(row_carry);
    col_rem_adv  = col_carry ? LEN_W'(col_sum - {1'b0, tw}) : LEN_W'(col_sum);
    row_rem_adv  = row_carry ? LEN_W'(row_sum - {1'b0, th}) : LEN_W'(row_sum);
    first        = (LEN_W'(sc_q) == col_start_q) && (LEN_W'(sr_q) == row_start_q);
    closing      = (sc_p1 == next_col_q) && (sr_p1 == next_row_q);
    row_end      = (tc_p1 >= tw);
    frame_end    = row_end && (tr_p1 >= th);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q        <= '0;
      sr_q        <= '0;
      tc_q        <= '0;
      tr_q        <= '0;
      col_start_q <= '0;
      row_start_q <= '0;
      next_col_q  <= '0;
      next_row_q  <= '0;
      col_rem_q   <= '0;
      row_rem_q   <= '0;
    end else if (cmd_i.restart) begin
      sc_q        <= '0;
      sr_q        <= '0;
      tc_q        <= '0;
      tr_q        <= '0;
      col_start_q <= '0;
      row_start_q <= '0;
      next_col_q  <= col_step;
      next_row_q  <= row_step;
      col_rem_q   <= col_left;
      row_rem_q   <= row_left;
    end else if (cmd_i.acc) begin
      if (sc_p1 >= rw) begin
        sc_q        <= '0;
        tc_q        <= '0;
        col_start_q <= '0;
        next_col_q  <= col_step;
        col_rem_q   <= col_left;
        if (sr_p1 >= rh) begin
          sr_q        <= '0;
          tr_q        <= '0;
          row_start_q <= '0;
          next_row_q  <= row_step;
          row_rem_q   <= row_left;
        end else begin
          if ((sr_p1 >= next_row_q) && (tr_p1 < th)) begin
            tr_q        <= IDX_W'(tr_p1);
            row_start_q <= next_row_q;
            next_row_q  <= next_row_adv;
            row_rem_q   <= row_rem_adv;
          end
          sr_q <= IDX_W'(sr_p1);
        end
      end else begin
        if ((sc_p1 >= next_col_q) && (tc_p1 < tw)) begin
          tc_q        <= TIDX_W'(tc_p1);
          col_start_q <= next_col_q;
          next_col_q  <= next_col_adv;
          col_rem_q   <= col_rem_adv;
        end
        sc_q <= IDX_W'(sc_p1);
      end
    end
  end

  // Pixel and product registers.
  logic [SAMPLE_BITS-1:0] pix_r_q, pix_g_q, pix_b_q, pix_a_q;
  logic [P_W-1:0]         prod_r_q, prod_g_q, prod_b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_r_q <= in_red_i[SAMPLE_BITS-1:0];
      pix_g_q <= in_green_i[SAMPLE_BITS-1:0];
      pix_b_q <= in_blue_i[SAMPLE_BITS-1:0];
      pix_a_q <= in_alpha_i[SAMPLE_BITS-1:0];
    end
    if (cmd_i.mul) begin
      prod_r_q <= pix_r_q * pix_a_q;
      prod_g_q <= pix_g_q * pix_a_q;
      prod_b_q <= pix_b_q * pix_a_q;
    end
  end

  // Line store: read at accept, read-modify-write in the accumulate cycle.
  boxd_pkg::line_entry_t rd_entry, wr_entry;
  logic [ENT_W-1:0]      rd_bits;

  boxd_ram #(.WIDTH(ENT_W), .DEPTH(MAX_TARGET_WIDTH)) u_line_ram (
    .clk_i, .we_i(cmd_i.acc), .waddr_i(tc_q), .wdata_i(wr_entry),
    .re_i(cmd_i.accept), .raddr_i(tc_q), .rdata_o(rd_bits)
  );

  assign rd_entry = boxd_pkg::line_entry_t'(rd_bits);

  always_comb begin
    if (first) begin
      wr_entry.sum_r = boxd_pkg::SUM_C_W'(prod_r_q);
      wr_entry.sum_g = boxd_pkg::SUM_C_W'(prod_g_q);
      wr_entry.sum_b = boxd_pkg::SUM_C_W'(prod_b_q);
      wr_entry.sum_a = boxd_pkg::SUM_A_W'(pix_a_q);
      wr_entry.cnt   = boxd_pkg::CNT_W'(1);
    end else begin
      wr_entry.sum_r = rd_entry.sum_r + boxd_pkg::SUM_C_W'(prod_r_q);
      wr_entry.sum_g = rd_entry.sum_g + boxd_pkg::SUM_C_W'(prod_g_q);
      wr_entry.sum_b = rd_entry.sum_b + boxd_pkg::SUM_C_W'(prod_b_q);
      wr_entry.sum_a = rd_entry.sum_a + boxd_pkg::SUM_A_W'(pix_a_q);
      wr_entry.cnt   = rd_entry.cnt + boxd_pkg::CNT_W'(1);
    end
  end

  // Closed box totals, held while the dividers run.
  boxd_pkg::line_entry_t acc_q;
  logic                  row_end_q, frame_end_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      acc_q       <= wr_entry;
      row_end_q   <= row_end;
      frame_end_q <= frame_end;
    end
  end

  // Round half up: q = (2*num + den) / (2*den).
  logic [boxd_pkg::CNT_W-1:0] cnt_eff;
  logic [CNUM_W-1:0]          c_den;
  logic [ANUM_W-1:0]          a_num, a_den;
  logic [CNUM_W-1:0]          r_num, g_num, b_num;

  always_comb begin
    cnt_eff = (acc_q.cnt == '0) ? boxd_pkg::CNT_W'(1) : acc_q.cnt;
    c_den   = CNUM_W'({acc_q.sum_a, 1'b0});
    r_num   = CNUM_W'({acc_q.sum_r, 1'b0}) + CNUM_W'(acc_q.sum_a);
    g_num   = CNUM_W'({acc_q.sum_g, 1'b0}) + CNUM_W'(acc_q.sum_a);
    b_num   = CNUM_W'({acc_q.sum_b, 1'b0}) + CNUM_W'(acc_q.sum_a);
    a_num   = ANUM_W'({acc_q.sum_a, 1'b0}) + ANUM_W'(cnt_eff);
    a_den   = ANUM_W'({cnt_eff, 1'b0});
  end

  logic [Q_W-1:0] q_r, q_g, q_b, q_a;
  logic           busy_r, busy_g, busy_b, busy_a;

  boxd_div #(.W(CNUM_W), .Q_W(Q_W)) u_div_r (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(r_num), .den_i(c_den),
    .busy_o(busy_r), .quot_o(q_r), .rem_o()
  );
  boxd_div #(.W(CNUM_W), .Q_W(Q_W)) u_div_g (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(g_num), .den_i(c_den),
    .busy_o(busy_g), .quot_o(q_g), .rem_o()
  );
  boxd_div #(.W(CNUM_W), .Q_W(Q_W)) u_div_b (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(b_num), .den_i(c_den),
    .busy_o(busy_b), .quot_o(q_b), .rem_o()
  );
  boxd_div #(.W(ANUM_W), .Q_W(Q_W)) u_div_a (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(a_num), .den_i(a_den),
    .busy_o(busy_a), .quot_o(q_a), .rem_o()
  );

  // Output register; a transparent box gives all zeros.
  logic                         clear_box;
  logic [boxd_pkg::FIELD_W-1:0] res_r, res_g, res_b, res_a;

  always_comb begin
    clear_box = (acc_q.sum_a == '0);
    res_r = clear_box ? '0 : boxd_pkg::FIELD_W'((q_r > SAMPLE_MAX) ? SAMPLE_MAX : q_r);
    res_g = clear_box ? '0 : boxd_pkg::FIELD_W'((q_g > SAMPLE_MAX) ? SAMPLE_MAX : q_g);
    res_b = clear_box ? '0 : boxd_pkg::FIELD_W'((q_b > SAMPLE_MAX) ? SAMPLE_MAX : q_b);
    res_a = clear_box ? '0 : boxd_pkg::FIELD_W'((q_a > SAMPLE_MAX) ? SAMPLE_MAX : q_a);
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_red_o    <= res_r;
      out_green_o  <= res_g;
      out_blue_o   <= res_b;
      out_alpha_o  <= res_a;
      row_done_o   <= row_end_q;
      frame_done_o <= frame_end_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.edge_busy = col_busy | row_busy;
  assign sts_o.div_busy  = busy_r | busy_g | busy_b | busy_a;
  assign sts_o.closing   = closing;
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

endmodule

`default_nettype wire

[design/boxd_ctrl.sv]
// ============================================================================
// Box downscaler controller
// Sequences setup, pixel accumulation, division and result hand-off.
// ============================================================================
`default_nettype none

module boxd_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_wr_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire boxd_pkg::dp_sts_t    sts_i,
  output boxd_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [7:0] {
    ST_SETUP  = 8'b0000_0001,
    ST_SWAIT  = 8'b0000_0010,
    ST_IDLE   = 8'b0000_0100,
    ST_MUL    = 8'b0000_1000,
    ST_ACC    = 8'b0001_0000,
    ST_DSTART = 8'b0010_0000,
    ST_DWAIT  = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_SETUP: begin
        cmd_o.edge_start = 1'b1;
        state_d = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (!sts_i.edge_busy) begin
          cmd_o.restart = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = sts_i.closing ? ST_DSTART : ST_IDLE;
      end
      ST_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (!sts_i.div_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_SETUP;
      end
    endcase
    // A register write restarts the frame and recomputes the box steps.
    if (cfg_wr_i) begin
      state_d = ST_SETUP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SETUP;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

`default_nettype wire

[design/box_downscale_premultiplied_unit.sv]
// ============================================================================
// Box downscaler, alpha weighted
// Area-averaging image reducer over a pixel stream with an APB register port.
// ============================================================================
// Usage: source pixels of the cropped region enter on pix_i in raster order,
// one item per handshake. Each pixel is added into the running sums of its
// box (r*a, g*a, b*a, a and a count) kept in a line store indexed by target
// column. When the last pixel of a box arrives, one target pixel leaves on
// res_o with colour = round(sum(c*a)/sum(a)) and alpha = round(sum(a)/count),
// plus row_done and frame_done flags. A transparent box yields all zeros.
// Items are handled one at a time. A pixel that closes no box is accepted,
// multiplied and accumulated with a line store read-modify-write. A pixel
// that closes a box also passes through the four iterative rounding
// dividers, which produce one quotient bit per cycle, and the load of the
// output register.
// After reset, and after every register write, the block computes the box
// steps of both axes with two small iterative dividers and restarts at the
// first pixel of a new frame; pix_i.ready is low meanwhile. The line store
// needs no clearing: every entry is written by the first pixel of its box
// before it is read.
// The output register holds a result while the receiver stalls; the next
// pixel is still accepted, and only a second closing box waits for it.
// ============================================================================
`default_nettype none

module box_downscale_premultiplied_unit #(
  parameter int unsigned MAX_REGION_DIM   = 4096,
  parameter int unsigned MAX_TARGET_WIDTH = 4096,
  parameter int unsigned SAMPLE_BITS      = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [boxd_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [boxd_pkg::PDATA_W-1:0]   pwdata,
  output logic      [boxd_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready,
  boxd_pix_if.sink                            pix_i,
  boxd_res_if.source                          res_o
);

  // Configuration registers.
  logic [boxd_pkg::CFG_W-1:0] region_width_q, region_height_q;
  logic [boxd_pkg::CFG_W-1:0] target_width_q, target_height_q;
  logic                       cfg_wr;
  boxd_pkg::cfg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = boxd_pkg::cfg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_width_q  <= boxd_pkg::CFG_RESET;
      region_height_q <= boxd_pkg::CFG_RESET;
      target_width_q  <= boxd_pkg::CFG_RESET;
      target_height_q <= boxd_pkg::CFG_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        boxd_pkg::REG_REGION_WIDTH:  region_width_q  <= pwdata[boxd_pkg::CFG_W-1:0];
        boxd_pkg::REG_REGION_HEIGHT: region_height_q <= pwdata[boxd_pkg::CFG_W-1:0];
        boxd_pkg::REG_TARGET_WIDTH:  target_width_q  <= pwdata[boxd_pkg::CFG_W-1:0];
        boxd_pkg::REG_TARGET_HEIGHT: target_height_q <= pwdata[boxd_pkg::CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      boxd_pkg::REG_REGION_WIDTH:  prdata = boxd_pkg::PDATA_W'(region_width_q);
      boxd_pkg::REG_REGION_HEIGHT: prdata = boxd_pkg::PDATA_W'(region_height_q);
      boxd_pkg::REG_TARGET_WIDTH:  prdata = boxd_pkg::PDATA_W'(target_width_q);
      boxd_pkg::REG_TARGET_HEIGHT: prdata = boxd_pkg::PDATA_W'(target_height_q);
      default:                     prdata = '0;
    endcase
  end

  boxd_pkg::ctrl_cmd_t cmd;
  boxd_pkg::dp_sts_t   sts;

  boxd_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_wr_i   (cfg_wr),
    .in_valid_i (pix_i.valid),
    .in_ready_o (pix_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  boxd_datapath #(
    .MAX_REGION_DIM   (MAX_REGION_DIM),
    .MAX_TARGET_WIDTH (MAX_TARGET_WIDTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .cmd_i           (cmd),
    .sts_o           (sts),
    .region_width_i  (region_width_q),
    .region_height_i (region_height_q),
    .target_width_i  (target_width_q),
    .target_height_i (target_height_q),
    .in_red_i        (pix_i.in_red),
    .in_green_i      (pix_i.in_green),
    .in_blue_i       (pix_i.in_blue),
    .in_alpha_i      (pix_i.in_alpha),
    .out_ready_i     (res_o.ready),
    .out_valid_o     (res_o.valid),
    .out_red_o       (res_o.out_red),
    .out_green_o     (res_o.out_green),
    .out_blue_o      (res_o.out_blue),
    .out_alpha_o     (res_o.out_alpha),
    .row_done_o      (res_o.row_done),
    .frame_done_o    (res_o.frame_done)
  );

endmodule

`default_nettype wire

[design/boxd_chk.sv]
// ============================================================================
// Box downscaler port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ============================================================================
`default_nettype none

module boxd_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_wr_i,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] out_red_i,
  input wire logic [15:0] out_green_i,
  input wire logic [15:0] out_blue_i,
  input wire logic [15:0] out_alpha_i,
  input wire logic        row_done_i,
  input wire logic        frame_done_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({out_red_i, out_green_i, out_blue_i,
                                             out_alpha_i, row_done_i, frame_done_i}))
    else $error("result payload changed while stalled");

  // The last pixel of a frame is also the last of its row.
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> row_done_i)
    else $error("frame_done without row_done");

  // Pixels are processed one at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second pixel accepted while one is in work");

  // A register write triggers the setup of the box steps.
  a_cfg_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr_i |=> !in_ready_i)
    else $error("pixel input ready right after a register write");

endmodule

bind box_downscale_premultiplied_unit boxd_chk u_boxd_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_wr_i     (psel & penable & pwrite & pready),
  .in_valid_i   (pix_i.valid),
  .in_ready_i   (pix_i.ready),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .out_red_i    (res_o.out_red),
  .out_green_i  (res_o.out_green),
  .out_blue_i   (res_o.out_blue),
  .out_alpha_i  (res_o.out_alpha),
  .row_done_i   (res_o.row_done),
  .frame_done_i (res_o.frame_done)
);

`default_nettype wire

[verif/tb_box_downscale_premultiplied_unit.sv]
// ============================================================================
// Box downscaler testbench
// Streams pixels through the alpha-weighted area downscaler under random
// sender gaps and receiver stalls, predicts every target pixel and compares.
// ============================================================================
`default_nettype none

module tb_box_downscale_premultiplied_unit;

  localparam int unsigned MAX_DIM     = 4096;
  localparam int unsigned MAX_TGT_W   = 4096;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  // Edge setup after a write plus the longest per-pixel path, with margin.
  localparam int unsigned SETTLE_CYCLES = 60;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic        row_done;
    logic        frame_done;
  } target_pixel_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [boxd_pkg::PADDR_W-1:0] paddr;
  logic [boxd_pkg::PDATA_W-1:0] pwdata;
  logic [boxd_pkg::PDATA_W-1:0] prdata;
  logic pready;

  boxd_pix_if pix ();
  boxd_res_if res ();

  box_downscale_premultiplied_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_i   (pix),
    .res_o   (res)
  );

  // Clock with a period of 10.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // --------------------------------------------------------------------------
  // Downscaler predictor: its own copy of the registers, the traversal
  // counters and the per-column line store.
  // --------------------------------------------------------------------------
  logic [boxd_pkg::CFG_W-1:0] cfg_regs [4];
  int unsigned src_col, src_row, box_col, box_row;
  int unsigned col_edge_next, row_edge_next;
  longint unsigned acc_red [MAX_TGT_W];
  longint unsigned acc_green [MAX_TGT_W];
  longint unsigned acc_blue [MAX_TGT_W];
  longint unsigned acc_alpha [MAX_TGT_W];
  int unsigned     acc_count [MAX_TGT_W];

  target_pixel_t expected_pixels [$];
  int unsigned   mismatches;
  int unsigned   cycles;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned region_w();
    return clamp_dim(cfg_regs[boxd_pkg::REG_REGION_WIDTH], MAX_DIM);
  endfunction

  function automatic int unsigned region_h();
    return clamp_dim(cfg_regs[boxd_pkg::REG_REGION_HEIGHT], MAX_DIM);
  endfunction

  // Target width is bounded by both the region width and the line store depth.
  function automatic int unsigned target_w();
    int unsigned lim;
    lim = (region_w() < MAX_TGT_W) ? region_w() : MAX_TGT_W;
    return clamp_dim(cfg_regs[boxd_pkg::REG_TARGET_WIDTH], lim);
  endfunction

  function automatic int unsigned target_h();
    return clamp_dim(cfg_regs[boxd_pkg::REG_TARGET_HEIGHT], region_h());
  endfunction

  function automatic int unsigned box_boundary(int unsigned i, int unsigned len,
                                               int unsigned n);
    longint unsigned prod;
    prod = longint'(i) * longint'(len);
    return int'(prod / n);
  endfunction

  // Division rounding half up, saturated to the sample range.
  function automatic logic [15:0] rounded_quotient(longint unsigned num,
                                                   longint unsigned den);
    longint unsigned q;
    q = (2 * num + den) / (2 * den);
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  task automatic restart_traversal();
    src_col = 0;
    src_row = 0;
    box_col = 0;
    box_row = 0;
    col_edge_next = box_boundary(1, region_w(), target_w());
    row_edge_next = box_boundary(1, region_h(), target_h());
  endtask

  // Folds one accepted pixel into its box and queues a target pixel when the
  // box closes.
  task automatic predict_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                               logic [15:0] a);
    int unsigned   rw, rh, tw, th, col;
    bit            opens, closes, row_end;
    longint unsigned sa, cnt;
    target_pixel_t tp;
    rw = region_w();
    rh = region_h();
    tw = target_w();
    th = target_h();
    col = (box_col >= MAX_TGT_W) ? MAX_TGT_W - 1 : box_col;
    opens = (src_col == box_boundary(box_col, rw, tw)) &&
            (src_row == box_boundary(box_row, rh, th));
    if (opens) begin
      acc_red[col]   = longint'(r) * longint'(a);
      acc_green[col] = longint'(g) * longint'(a);
      acc_blue[col]  = longint'(b) * longint'(a);
      acc_alpha[col] = a;
      acc_count[col] = 1;
    end else begin
      acc_red[col]   += longint'(r) * longint'(a);
      acc_green[col] += longint'(g) * longint'(a);
      acc_blue[col]  += longint'(b) * longint'(a);
      acc_alpha[col] += a;
      acc_count[col] = (acc_count[col] + 1) & 32'h1FF_FFFF;
    end

    closes = (src_col + 1 == col_edge_next) && (src_row + 1 == row_edge_next);
    if (closes) begin
      sa = acc_alpha[col];
      cnt = (acc_count[col] != 0) ? acc_count[col] : 1;
      row_end = (box_col + 1 >= tw);
      if (sa == 0) begin
        // A fully transparent box gives zero colour and zero alpha.
        tp.red = '0;
        tp.green = '0;
        tp.blue = '0;
        tp.alpha = '0;
      end else begin
        tp.red   = rounded_quotient(acc_red[col], sa);
        tp.green = rounded_quotient(acc_green[col], sa);
        tp.blue  = rounded_quotient(acc_blue[col], sa);
        tp.alpha = rounded_quotient(sa, cnt);
      end
      tp.row_done = row_end;
      tp.frame_done = row_end && (box_row + 1 >= th);
      expected_pixels.push_back(tp);
    end

    // Advance through the region; wraps to a new frame at its end.
    if (src_col + 1 >= rw) begin
      src_col = 0;
      box_col = 0;
      col_edge_next = box_boundary(1, rw, tw);
      if (src_row + 1 >= rh) begin
        src_row = 0;
        box_row = 0;
        row_edge_next = box_boundary(1, rh, th);
      end else begin
        if (src_row + 1 >= row_edge_next && box_row + 1 < th) begin
          box_row++;
          row_edge_next = box_boundary(box_row + 1, rh, th);
        end
        src_row++;
      end
    end else begin
      if (src_col + 1 >= col_edge_next && box_col + 1 < tw) begin
        box_col++;
        col_edge_next = box_boundary(box_col + 1, rw, tw);
      end
      src_col++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Pixel sender. The sender works in bursts; between most bursts valid drops
  // for a random gap. Every task starts and ends at a rising edge.
  // --------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned pixels_sent;

  task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                            logic [15:0] a);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        pix.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    pix.valid    <= 1'b1;
    pix.in_red   <= r;
    pix.in_green <= g;
    pix.in_blue  <= b;
    pix.in_alpha <= a;
    do @(posedge clk_i); while (!pix.ready);
    predict_pixel(r, g, b, a);
    pixels_sent++;
  endtask

  // Lowers valid and lets the block drain, including pixels still in flight
  // that close no box.
  task automatic wait_drained();
    pix.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Register port. Writes go in only while the block is drained.
  // --------------------------------------------------------------------------
  task automatic write_register(boxd_pkg::cfg_idx_e idx,
                                logic [boxd_pkg::PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= boxd_pkg::PADDR_W'(4 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_regs[idx] = value[boxd_pkg::CFG_W-1:0];
    restart_traversal();
    // Read back the register that was just written.
    psel  <= 1'b1;
    paddr <= boxd_pkg::PADDR_W'(4 * idx);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[boxd_pkg::CFG_W-1:0] !== cfg_regs[idx]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d read back %h, expected %h", idx,
                 prdata[boxd_pkg::CFG_W-1:0], cfg_regs[idx]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Upper bits of the data word are noise that the register must drop.
  task automatic set_sizes(int unsigned rw, int unsigned rh, int unsigned tw,
                           int unsigned th);
    wait_drained();
    write_register(boxd_pkg::REG_REGION_WIDTH,  ($urandom & 32'hFFFF_E000) | rw);
    write_register(boxd_pkg::REG_REGION_HEIGHT, ($urandom & 32'hFFFF_E000) | rh);
    write_register(boxd_pkg::REG_TARGET_WIDTH,  ($urandom & 32'hFFFF_E000) | tw);
    write_register(boxd_pkg::REG_TARGET_HEIGHT, ($urandom & 32'hFFFF_E000) | th);
  endtask

  // Alpha leans toward the transparent and opaque extremes.
  function automatic logic [15:0] random_alpha();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_pixels(int unsigned n, bit clear_alpha);
    for (int unsigned i = 0; i < n; i++)
      send_pixel(16'($urandom), 16'($urandom), 16'($urandom),
                 clear_alpha ? 16'h0000 : random_alpha());
  endtask

  // --------------------------------------------------------------------------
  // Result checker with its own stall pattern: runs of steady ready that never
  // stall, and runs of random stalls.
  // --------------------------------------------------------------------------
  int unsigned stall_run;
  bit          stall_mode;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected target pixel %h %h %h %h", res.out_red,
                     res.out_green, res.out_blue, res.out_alpha);
        end else begin
          target_pixel_t tp;
          tp = expected_pixels.pop_front();
          if (res.out_red !== tp.red || res.out_green !== tp.green ||
              res.out_blue !== tp.blue || res.out_alpha !== tp.alpha ||
              res.row_done !== tp.row_done || res.frame_done !== tp.frame_done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("target pixel mismatch: got rgba %h %h %h %h row %b frame %b, expected rgba %h %h %h %h row %b frame %b",
                       res.out_red, res.out_green, res.out_blue, res.out_alpha,
                       res.row_done, res.frame_done, tp.red, tp.green, tp.blue,
                       tp.alpha, tp.row_done, tp.frame_done);
          end
        end
      end
      if (stall_run == 0) begin
        stall_run = $urandom_range(1, 40);
        stall_mode = ($urandom_range(0, 2) == 0);
      end
      stall_run--;
      res.ready <= stall_mode ? ($urandom_range(0, 1) == 1) : 1'b1;
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset sizes give one-to-one scaling, so every pixel is its own box.
  task automatic test_reset_scaling();
    send_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'h0001);
    send_pixel(16'h1234, 16'h5678, 16'h9ABC, 16'h0000);
    send_random_pixels(3, 1'b0);
  endtask

  // Extremes of the samples, transparent boxes and half-way rounding.
  task automatic test_directed_boxes();
    set_sizes(2, 2, 1, 1);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_pixel(16'h8000, 16'h0001, 16'hFFFF, 16'h0000);
    send_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    send_pixel(16'h7FFF, 16'h0000, 16'h0001, 16'h0000);
    send_pixel(16'h0001, 16'h0000, 16'h0000, 16'h0001);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'h0001, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0001);
  endtask

  // Zero sizes count as one; oversized values clamp to the region and limit.
  task automatic test_size_clamps();
    set_sizes(0, 0, 0, 0);
    send_random_pixels(3, 1'b0);
    set_sizes(3, 2, 8191, 8191);
    send_random_pixels(6, 1'b0);
    set_sizes(5, 3, 0, 2);
    send_random_pixels(15, 1'b0);
  endtask

  // Large regions: the start of a row of the largest line store, a single
  // box spanning a long two-row region, and the tallest region.
  task automatic test_wide_rows();
    set_sizes(8191, 1, 4096, 1);
    send_random_pixels(200, 1'b0);
    set_sizes(300, 2, 1, 1);
    send_random_pixels(600, 1'b0);
    set_sizes(1, 8191, 1, 4095);
    send_random_pixels(200, 1'b0);
  endtask

  // Random small sizes, mostly whole frames, some cut short by a new write.
  task automatic test_random_frames();
    int unsigned start, rw, rh, frame_len;
    bit          clear_alpha;
    start = pixels_sent;
    while (pixels_sent - start < 700) begin
      rw = $urandom_range(1, 12);
      rh = $urandom_range(1, 10);
      set_sizes(rw, rh, $urandom_range(0, rw + 2), $urandom_range(0, rh + 2));
      frame_len = rw * rh;
      clear_alpha = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 5) == 0)
        send_random_pixels($urandom_range(1, frame_len), clear_alpha);
      else
        send_random_pixels(frame_len * $urandom_range(1, 3), clear_alpha);
      // Now and then hold the sender until every result is out.
      if ($urandom_range(0, 7) == 0) begin
        pix.valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pix.valid    = 1'b0;
    pix.in_red   = '0;
    pix.in_green = '0;
    pix.in_blue  = '0;
    pix.in_alpha = '0;
    res.ready    = 1'b0;
    mismatches   = 0;
    cycles       = 0;
    burst_left   = 0;
    pixels_sent  = 0;
    stall_run    = 0;
    stall_mode   = 1'b0;
    for (int i = 0; i < 4; i++) cfg_regs[i] = boxd_pkg::CFG_RESET;
    restart_traversal();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_scaling();
    test_directed_boxes();
    test_size_clamps();
    test_wide_rows();
    test_random_frames();

    wait_drained();
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
